// ===== rtl/dnsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsd_pkg
// Shared constants, codes and types of the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnsd_pkg;

	localparam int MESSAGE_BYTES    = 512;
	localparam int MAX_NAME_BYTES   = 255;
	localparam int MAX_POINTER_HOPS = 8;
	localparam int MAX_RESULTS      = 32;

	localparam int ADDR_W  = $clog2(MESSAGE_BYTES);
	localparam int CUR_W   = 17;
	localparam int EMIT_W  = $clog2(MAX_NAME_BYTES + 1);
	localparam int HOP_W   = $clog2(MAX_POINTER_HOPS + 1);
	localparam int WORDS_W = $clog2(MAX_RESULTS);
	localparam int SUM_W   = 12;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_HOPS     = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	typedef struct packed {
		logic       clear;
		logic       push;
		logic [7:0] data;
		logic       finish;
		logic [1:0] status;
		logic [8:0] next_offset;
	} pack_ctl_t;

endpackage

// ===== rtl/dnsd_ram.sv =====
// ----------------------------------------------------------------------------
// dnsd_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dnsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/dnsd_packer.sv =====
// ----------------------------------------------------------------------------
// dnsd_packer
// Packs name bytes eight to a word and drives the registered result ports.
// ----------------------------------------------------------------------------
module dnsd_packer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dnsd_pkg::pack_ctl_t        ctl,
	output logic [dnsd_pkg::EMIT_W-1:0] emitted,
	output logic                       strobe,
	output logic [63:0]                name_word,
	output logic [3:0]                 byte_count,
	output logic                       last,
	output logic [8:0]                 next_offset,
	output logic [7:0]                 name_length,
	output logic [1:0]                 status
);

	logic [63:0]                      pack_q, pack_d;
	logic [3:0]                       fill_q, fill_d;
	logic [dnsd_pkg::EMIT_W-1:0]      emit_q, emit_d;
	logic [dnsd_pkg::WORDS_W-1:0]     words_q, words_d;
	logic                             strobe_d;
	logic [63:0]                      word_d;
	logic [3:0]                       count_d;
	logic                             last_d;
	logic [8:0]                       next_d;
	logic [7:0]                       len_d;
	logic [1:0]                       status_d;

	assign emitted = emit_q;

	always_comb begin
		pack_d   = pack_q;
		fill_d   = fill_q;
		emit_d   = emit_q;
		words_d  = words_q;
		strobe_d = 1'b0;
		word_d   = pack_q;
		count_d  = fill_q;
		last_d   = 1'b0;
		next_d   = '0;
		len_d    = '0;
		status_d = '0;
		if (ctl.clear) begin
			pack_d  = '0;
			fill_d  = '0;
			emit_d  = '0;
			words_d = '0;
		end else if (ctl.push) begin
			emit_d = emit_q + 1'b1;
			if (fill_q == 4'd8) begin
				if (words_q < dnsd_pkg::WORDS_W'(dnsd_pkg::MAX_RESULTS - 1)) begin
					strobe_d = 1'b1;
					words_d  = words_q + 1'b1;
				end
				pack_d = {56'd0, ctl.data};
				fill_d = 4'd1;
			end else begin
				pack_d[8*fill_q[2:0] +: 8] = ctl.data;
				fill_d = fill_q + 4'd1;
			end
		end else if (ctl.finish) begin
			strobe_d = 1'b1;
			last_d   = 1'b1;
			next_d   = ctl.next_offset;
			len_d    = 8'(emit_q);
			status_d = ctl.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_q  <= '0;
			fill_q  <= '0;
			emit_q  <= '0;
			words_q <= '0;
			strobe  <= 1'b0;
		end else begin
			pack_q  <= pack_d;
			fill_q  <= fill_d;
			emit_q  <= emit_d;
			words_q <= words_d;
			strobe  <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (strobe_d) begin
			name_word   <= word_d;
			byte_count  <= count_d;
			last        <= last_d;
			next_offset <= next_d;
			name_length <= len_d;
			status      <= status_d;
		end
	end

endmodule

// ===== rtl/dnsd_walker.sv =====
// ----------------------------------------------------------------------------
// dnsd_walker
// Sequencer that walks labels and pointers through the message store.
// ----------------------------------------------------------------------------
module dnsd_walker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        command,
	input  logic [8:0]                  start_offset,
	input  logic [dnsd_pkg::EMIT_W-1:0] emitted,
	input  logic [7:0]                  rd_data,
	output logic [dnsd_pkg::ADDR_W-1:0] rd_addr,
	output logic                        busy,
	output dnsd_pkg::pack_ctl_t         ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HEAD = 2'd1;
	localparam logic [1:0] S_PTR  = 2'd2;
	localparam logic [1:0] S_COPY = 2'd3;

	localparam logic [dnsd_pkg::CUR_W-1:0] MSG_END =
		dnsd_pkg::CUR_W'(dnsd_pkg::MESSAGE_BYTES);

	logic [1:0]                  state_q, state_d;
	logic [dnsd_pkg::CUR_W-1:0]  cursor_q, cursor_d;
	logic [dnsd_pkg::CUR_W-1:0]  resume_q, resume_d;
	logic                        seen_q, seen_d;
	logic [dnsd_pkg::HOP_W-1:0]  hop_q, hop_d;
	logic [7:0]                  rem_q, rem_d;
	logic [5:0]                  hi_q, hi_d;
	logic [dnsd_pkg::CUR_W-1:0]  cursor_inc;
	logic [dnsd_pkg::CUR_W-1:0]  target;
	logic [dnsd_pkg::SUM_W-1:0]  need;

	assign busy       = (state_q != S_IDLE);
	assign rd_addr    = cursor_d[dnsd_pkg::ADDR_W-1:0];
	assign cursor_inc = cursor_q + 1'b1;
	assign target     = dnsd_pkg::CUR_W'({hi_q, rd_data});
	assign need       = dnsd_pkg::SUM_W'(emitted) + dnsd_pkg::SUM_W'(rd_data)
		+ dnsd_pkg::SUM_W'(2);

	always_comb begin
		state_d  = state_q;
		cursor_d = cursor_q;
		resume_d = resume_q;
		seen_d   = seen_q;
		hop_d    = hop_q;
		rem_d    = rem_q;
		hi_d     = hi_q;
		ctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start && command == dnsd_pkg::CMD_DECODE) begin
					ctl.clear = 1'b1;
					cursor_d  = dnsd_pkg::CUR_W'(start_offset);
					resume_d  = '0;
					seen_d    = 1'b0;
					hop_d     = '0;
					rem_d     = '0;
					state_d   = S_HEAD;
				end
			end
			S_HEAD: begin
				if (cursor_q >= MSG_END) begin
					ctl.finish = 1'b1;
					ctl.status = dnsd_pkg::ST_RANGE;
					state_d    = S_IDLE;
				end else if (rd_data == 8'd0) begin
					ctl.finish      = 1'b1;
					ctl.status      = dnsd_pkg::ST_OK;
					ctl.next_offset = seen_q ? resume_q[8:0] : cursor_inc[8:0];
					state_d         = S_IDLE;
				end else if (rd_data[7:6] == 2'b11) begin
					if (cursor_inc >= MSG_END) begin
						ctl.finish = 1'b1;
						ctl.status = dnsd_pkg::ST_RANGE;
						state_d    = S_IDLE;
					end else begin
						hi_d = rd_data[5:0];
						if (!seen_q) begin
							seen_d   = 1'b1;
							resume_d = cursor_inc + 1'b1;
						end
						cursor_d = cursor_inc;
						state_d  = S_PTR;
					end
				end else if (need > dnsd_pkg::SUM_W'(dnsd_pkg::MAX_NAME_BYTES)) begin
					ctl.finish = 1'b1;
					ctl.status = dnsd_pkg::ST_TOO_LONG;
					state_d    = S_IDLE;
				end else if (cursor_q + dnsd_pkg::CUR_W'(rd_data) >= MSG_END) begin
					ctl.finish = 1'b1;
					ctl.status = dnsd_pkg::ST_RANGE;
					state_d    = S_IDLE;
				end else begin
					ctl.push = 1'b1;
					ctl.data = rd_data;
					rem_d    = rd_data;
					cursor_d = cursor_inc;
					state_d  = S_COPY;
				end
			end
			S_PTR: begin
				if (hop_q >= dnsd_pkg::HOP_W'(dnsd_pkg::MAX_POINTER_HOPS)) begin
					ctl.finish = 1'b1;
					ctl.status = dnsd_pkg::ST_HOPS;
					state_d    = S_IDLE;
				end else if (target >= MSG_END) begin
					ctl.finish = 1'b1;
					ctl.status = dnsd_pkg::ST_RANGE;
					state_d    = S_IDLE;
				end else begin
					hop_d    = hop_q + 1'b1;
					cursor_d = target;
					state_d  = S_HEAD;
				end
			end
			S_COPY: begin
				ctl.push = 1'b1;
				ctl.data = rd_data;
				cursor_d = cursor_inc;
				rem_d    = rem_q - 8'd1;
				if (rem_q == 8'd1) begin
					state_d = S_HEAD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			resume_q <= '0;
			seen_q   <= 1'b0;
			hop_q    <= '0;
			rem_q    <= '0;
			hi_q     <= '0;
		end else begin
			state_q  <= state_d;
			cursor_q <= cursor_d;
			resume_q <= resume_d;
			seen_q   <= seen_d;
			hop_q    <= hop_d;
			rem_q    <= rem_d;
			hi_q     <= hi_d;
		end
	end

endmodule

// ===== rtl/dns_name_decompressor_top.sv =====
// ----------------------------------------------------------------------------
// dns_name_decompressor_top
// Stores a DNS message and decompresses names from it into packed words.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low.
// A load transaction (command 0) writes load_byte at load_address in the
// message store; it produces no result and busy stays low.
// A decode transaction (command 1) walks the name at start_offset. Busy is
// high while the walk runs and each result appears for one cycle with
// strobe high; the receiver cannot stall and must take every result.
// The walker reads the store one byte per cycle through its registered read
// port: each emitted name byte is read once, each pointer hop reads both
// pointer bytes, and the terminating zero ends the walk. The final word of
// a decode is on the ports in the first cycle with busy low.
// Full words appear while the walk continues; the last word carries the
// offset after the name, the name length and the status.
// Reset clears the sequencer and the packer at once; the message store is
// not cleared and must be loaded before it is decoded.
// ----------------------------------------------------------------------------
module dns_name_decompressor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [8:0]  load_address,
	input  logic [7:0]  load_byte,
	input  logic [8:0]  start_offset,
	output logic        strobe,
	output logic [63:0] name_word,
	output logic [3:0]  byte_count,
	output logic        last,
	output logic [8:0]  next_offset,
	output logic [7:0]  name_length,
	output logic [1:0]  status
);

	logic                        we;
	logic [dnsd_pkg::ADDR_W-1:0] rd_addr;
	logic [7:0]                  rd_data;
	logic [dnsd_pkg::EMIT_W-1:0] emitted;
	dnsd_pkg::pack_ctl_t         ctl;

	assign we = start && !busy && (command == dnsd_pkg::CMD_LOAD)
		&& (32'(load_address) < 32'(dnsd_pkg::MESSAGE_BYTES));

	dnsd_ram #(
		.WIDTH(8),
		.DEPTH(dnsd_pkg::MESSAGE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(dnsd_pkg::ADDR_W'(load_address)),
		.wdata(load_byte),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	dnsd_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.command     (command),
		.start_offset(start_offset),
		.emitted     (emitted),
		.rd_data     (rd_data),
		.rd_addr     (rd_addr),
		.busy        (busy),
		.ctl         (ctl)
	);

	dnsd_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.emitted    (emitted),
		.strobe     (strobe),
		.name_word  (name_word),
		.byte_count (byte_count),
		.last       (last),
		.next_offset(next_offset),
		.name_length(name_length),
		.status     (status)
	);

endmodule
